### hw/rtl/ab4_pkg.sv
// shared widths, codes and types of the adams-bashforth integrator
`default_nettype none

package ab4_pkg;

	// item and register widths
	localparam int VALUE_WIDTH = 48;
	localparam int STEP_WIDTH  = 24;
	localparam int KIND_WIDTH  = 3;

	// stages between the input and the value registers
	localparam int PIPE_DEPTH = 7;

	// datapath widths
	localparam int SUM_W     = VALUE_WIDTH + 8;
	localparam int MAG_W     = SUM_W - 1;
	localparam int PP_LO_W   = MAG_W / 2;
	localparam int PP_HI_W   = MAG_W - PP_LO_W;
	localparam int PROD_W    = MAG_W + STEP_WIDTH;
	localparam int RND_SHIFT = STEP_WIDTH + 3;
	localparam int QUO_W     = PROD_W - RND_SHIFT;
	localparam int U0_W      = QUO_W + 1;
	localparam int U2_W      = U0_W + 7;
	localparam int U4_W      = U0_W + 31;
	localparam int U5_W      = U0_W + 63;
	localparam int ACC_W     = QUO_W + 2;

	// item kinds
	localparam logic [KIND_WIDTH-1:0] KIND_STEP_VEC = KIND_WIDTH'(0);
	localparam logic [KIND_WIDTH-1:0] KIND_STEP_X   = KIND_WIDTH'(1);
	localparam logic [KIND_WIDTH-1:0] KIND_LOAD_VEC = KIND_WIDTH'(2);
	localparam logic [KIND_WIDTH-1:0] KIND_LOAD_X   = KIND_WIDTH'(3);
	localparam logic [KIND_WIDTH-1:0] KIND_CLEAR    = KIND_WIDTH'(4);

	// saturation limits
	localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	typedef enum logic [1:0] {
		HIST_HOLD,
		HIST_PUSH,
		HIST_CLEAR
	} hist_op_t;

	typedef enum logic [1:0] {
		VAL_HOLD,
		VAL_STEP,
		VAL_LOAD,
		VAL_ZERO
	} val_op_t;

	// per-lane pipeline control from the top level
	typedef struct packed {
		logic                  accept;
		logic [PIPE_DEPTH-1:0] ld;
		logic                  commit;
		hist_op_t              hop;
		val_op_t               vop;
	} lane_ctl_t;

	// sign extension of a value into the tap sum width
	function automatic logic signed [SUM_W-1:0] widen(input logic [VALUE_WIDTH-1:0] v);
		return {{(SUM_W-VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v};
	endfunction

endpackage

`default_nettype wire

### hw/rtl/ab4_lane.sv
// one vector component: slope history, step datapath and value registers
`default_nettype none

module ab4_lane
	import ab4_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire lane_ctl_t              ctl,
	input  wire logic [STEP_WIDTH-1:0]  step,
	input  wire logic [VALUE_WIDTH-1:0] operand,
	output logic      [VALUE_WIDTH-1:0] value,
	output logic      [VALUE_WIDTH-1:0] prior,
	output logic                        sat
);

	localparam logic signed [SUM_W-1:0] C55 = SUM_W'(55);
	localparam logic signed [SUM_W-1:0] C59 = SUM_W'(59);
	localparam logic signed [SUM_W-1:0] C37 = SUM_W'(37);
	localparam logic signed [SUM_W-1:0] C9  = SUM_W'(9);
	localparam logic [PROD_W:0] HALF = (PROD_W+1)'(3) << (RND_SHIFT - 1);

	logic [VALUE_WIDTH-1:0] hist_q [4];
	logic [VALUE_WIDTH-1:0] value_q, prior_q;
	logic                   sat_q;

	// stage registers
	logic signed [SUM_W-1:0]         a_s1, b_s1;
	logic [MAG_W-1:0]                mag_s2;
	logic [PP_LO_W+STEP_WIDTH-1:0]   pp_lo_s3;
	logic [PP_HI_W+STEP_WIDTH-1:0]   pp_hi_s3;
	logic [QUO_W-1:0]                quo_s4;
	logic [U2_W-1:0]                 u2_s5;
	logic [U4_W-1:0]                 u4_s6;
	logic [QUO_W-1:0]                quo_s7;
	logic neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	val_op_t vop_s1, vop_s2, vop_s3, vop_s4, vop_s5, vop_s6, vop_s7;
	logic [VALUE_WIDTH-1:0] opnd_s1, opnd_s2, opnd_s3, opnd_s4, opnd_s5, opnd_s6, opnd_s7;

	logic signed [SUM_W-1:0] tap_sum;
	logic [SUM_W-1:0]        tap_abs;
	logic [PROD_W:0]         prod_rnd;
	logic [U0_W-1:0]         u0;
	logic [U5_W-1:0]         u5;
	logic signed [ACC_W-1:0] acc, acc_max, acc_min, cur;
	logic signed [ACC_W-1:0] inc;
	logic                    clip_hi, clip_lo;
	logic [VALUE_WIDTH-1:0]  stepped;

	// slope history, newest entry first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) hist_q[i] <= '0;
		end else if (ctl.accept) begin
			unique case (ctl.hop)
				HIST_PUSH: begin
					hist_q[0] <= operand;
					hist_q[1] <= hist_q[0];
					hist_q[2] <= hist_q[1];
					hist_q[3] <= hist_q[2];
				end
				HIST_CLEAR: begin
					for (int i = 0; i < 4; i++) hist_q[i] <= '0;
				end
				default: ;
			endcase
		end
	end

	// tap magnitude and rounding sum
	always_comb begin
		tap_sum  = a_s1 + b_s1;
		tap_abs  = tap_sum[SUM_W-1] ? -tap_sum : tap_sum;
		prod_rnd = (PROD_W+1)'({pp_hi_s3, {PP_LO_W{1'b0}}}) + (PROD_W+1)'(pp_lo_s3) + HALF;
		u0       = U0_W'(quo_s4) + U0_W'(1);
		u5       = U5_W'(u4_s6) + (U5_W'(u4_s6) << 32);
	end

	// datapath stages
	always_ff @(posedge clk) begin
		// weighted taps, the new slope counts as the newest entry
		if (ctl.ld[0]) begin
			a_s1    <= C55 * widen(operand) - C59 * widen(hist_q[0]);
			b_s1    <= C37 * widen(hist_q[1]) - C9 * widen(hist_q[2]);
			vop_s1  <= ctl.vop;
			opnd_s1 <= operand;
		end
		// sign and magnitude of the tap sum
		if (ctl.ld[1]) begin
			mag_s2  <= tap_abs[MAG_W-1:0];
			neg_s2  <= tap_sum[SUM_W-1];
			vop_s2  <= vop_s1;
			opnd_s2 <= opnd_s1;
		end
		// split product by the time step
		if (ctl.ld[2]) begin
			pp_lo_s3 <= (PP_LO_W+STEP_WIDTH)'(mag_s2[PP_LO_W-1:0])
				* (PP_LO_W+STEP_WIDTH)'(step);
			pp_hi_s3 <= (PP_HI_W+STEP_WIDTH)'(mag_s2[MAG_W-1:PP_LO_W])
				* (PP_HI_W+STEP_WIDTH)'(step);
			neg_s3   <= neg_s2;
			vop_s3   <= vop_s2;
			opnd_s3  <= opnd_s2;
		end
		// round half up and drop the power-of-two part of the divisor
		if (ctl.ld[3]) begin
			quo_s4  <= prod_rnd[RND_SHIFT +: QUO_W];
			neg_s4  <= neg_s3;
			vop_s4  <= vop_s3;
			opnd_s4 <= opnd_s3;
		end
		// divide by three: (x+1)*(2^64-1)/3 built from shift-add factors
		if (ctl.ld[4]) begin
			u2_s5   <= U2_W'(u0) * U2_W'(85);
			neg_s5  <= neg_s4;
			vop_s5  <= vop_s4;
			opnd_s5 <= opnd_s4;
		end
		if (ctl.ld[5]) begin
			u4_s6   <= U4_W'(u2_s5) * U4_W'(32'd16843009);
			neg_s6  <= neg_s5;
			vop_s6  <= vop_s5;
			opnd_s6 <= opnd_s5;
		end
		if (ctl.ld[6]) begin
			quo_s7  <= u5[U5_W-1 -: QUO_W];
			neg_s7  <= neg_s6;
			vop_s7  <= vop_s6;
			opnd_s7 <= opnd_s6;
		end
	end

	// accumulate with saturation
	always_comb begin
		cur     = ACC_W'($signed(value_q));
		inc     = $signed(ACC_W'(quo_s7));
		acc     = neg_s7 ? cur - inc : cur + inc;
		acc_max = ACC_W'(VAL_MAX);
		acc_min = ACC_W'(VAL_MIN);
		clip_hi = acc > acc_max;
		clip_lo = acc < acc_min;
		if (clip_hi)
			stepped = VAL_MAX;
		else if (clip_lo)
			stepped = VAL_MIN;
		else
			stepped = acc[VALUE_WIDTH-1:0];
	end

	// value state, also the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			prior_q <= '0;
			sat_q   <= 1'b0;
		end else if (ctl.commit) begin
			unique case (vop_s7)
				VAL_STEP: begin
					prior_q <= value_q;
					value_q <= stepped;
					sat_q   <= clip_hi | clip_lo;
				end
				VAL_LOAD: begin
					prior_q <= opnd_s7;
					value_q <= opnd_s7;
					sat_q   <= 1'b0;
				end
				VAL_ZERO: begin
					prior_q <= '0;
					value_q <= '0;
					sat_q   <= 1'b0;
				end
				default: begin
					sat_q <= 1'b0;
				end
			endcase
		end
	end

	assign value = value_q;
	assign prior = prior_q;
	assign sat   = sat_q;

endmodule

`default_nettype wire

### hw/rtl/adams_bashforth4_integrator_top.sv
// top level of the two-component adams-bashforth integrator

// Fourth-order Adams-Bashforth integrator for an (x, y) pair in signed Q31.16.
// One item enters per clock while in_ready is high, and its result is presented
// once it has passed seven datapath stages (tap sum, magnitude, split
// multiply by the step, rounding, two shift-add factors and a final add for
// the divide by three), the last of which feeds the value register, which is
// also the result register. The slope history is updated when an item is
// accepted and the values when its result is registered, so items stream
// without gaps; the combinational accumulate-and-saturate loop on the value
// registers sets the clock rate. in_ready falls only when every stage is full
// and a result waits. step_size must be written through cfg_wr_en/cfg_wr_data
// only while no item is in flight; the block itself does not enforce this.
`default_nettype none

module adams_bashforth4_integrator_top
	import ab4_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic [STEP_WIDTH-1:0]  cfg_wr_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [KIND_WIDTH-1:0]  kind,
	input  wire logic [VALUE_WIDTH-1:0] operand_x,
	input  wire logic [VALUE_WIDTH-1:0] operand_y,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [VALUE_WIDTH-1:0] value_x,
	output logic      [VALUE_WIDTH-1:0] value_y,
	output logic      [VALUE_WIDTH-1:0] previous_x,
	output logic      [VALUE_WIDTH-1:0] previous_y,
	output logic                        saturated
);

	logic [STEP_WIDTH-1:0] step_q;
	logic [PIPE_DEPTH-1:0] vld_q;
	logic                  out_valid_q;
	logic [PIPE_DEPTH-1:0] ld;
	logic                  ld_out;
	logic                  accept;
	lane_ctl_t             ctl_x, ctl_y;
	logic                  sat_x, sat_y;

	// step size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= '0;
		else if (cfg_wr_en)
			step_q <= cfg_wr_data;
	end

	// a stage loads when it is empty or its successor loads
	always_comb begin
		ld_out = !out_valid_q || out_ready;
		ld[PIPE_DEPTH-1] = !vld_q[PIPE_DEPTH-1] || ld_out;
		for (int k = PIPE_DEPTH - 2; k >= 0; k--)
			ld[k] = !vld_q[k] || ld[k+1];
	end

	assign in_ready = ld[0];
	assign accept   = in_valid && in_ready;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld[0])
				vld_q[0] <= in_valid;
			for (int k = 1; k < PIPE_DEPTH; k++)
				if (ld[k])
					vld_q[k] <= vld_q[k-1];
			if (ld_out)
				out_valid_q <= vld_q[PIPE_DEPTH-1];
		end
	end

	// kind decode into per-lane operations
	always_comb begin
		ctl_x.accept = accept;
		ctl_x.ld     = ld;
		ctl_x.commit = ld_out && vld_q[PIPE_DEPTH-1];
		ctl_y.accept = accept;
		ctl_y.ld     = ld;
		ctl_y.commit = ld_out && vld_q[PIPE_DEPTH-1];
		unique case (kind)
			KIND_STEP_VEC: begin
				ctl_x.hop = HIST_PUSH;  ctl_x.vop = VAL_STEP;
				ctl_y.hop = HIST_PUSH;  ctl_y.vop = VAL_STEP;
			end
			KIND_STEP_X: begin
				ctl_x.hop = HIST_PUSH;  ctl_x.vop = VAL_STEP;
				ctl_y.hop = HIST_HOLD;  ctl_y.vop = VAL_HOLD;
			end
			KIND_LOAD_VEC: begin
				ctl_x.hop = HIST_CLEAR; ctl_x.vop = VAL_LOAD;
				ctl_y.hop = HIST_CLEAR; ctl_y.vop = VAL_LOAD;
			end
			KIND_LOAD_X: begin
				ctl_x.hop = HIST_CLEAR; ctl_x.vop = VAL_LOAD;
				ctl_y.hop = HIST_CLEAR; ctl_y.vop = VAL_HOLD;
			end
			KIND_CLEAR: begin
				ctl_x.hop = HIST_CLEAR; ctl_x.vop = VAL_ZERO;
				ctl_y.hop = HIST_CLEAR; ctl_y.vop = VAL_ZERO;
			end
			default: begin
				ctl_x.hop = HIST_HOLD;  ctl_x.vop = VAL_HOLD;
				ctl_y.hop = HIST_HOLD;  ctl_y.vop = VAL_HOLD;
			end
		endcase
	end

	// x and y lanes
	ab4_lane u_lane_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_x),
		.step    (step_q),
		.operand (operand_x),
		.value   (value_x),
		.prior   (previous_x),
		.sat     (sat_x)
	);

	ab4_lane u_lane_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_y),
		.step    (step_q),
		.operand (operand_y),
		.value   (value_y),
		.prior   (previous_y),
		.sat     (sat_y)
	);

	assign out_valid = out_valid_q;
	assign saturated = sat_x | sat_y;

endmodule

`default_nettype wire

### hw/rtl/ab4_checker.sv
// port-level checks of the integrator top level and their binding
`default_nettype none

module ab4_checker
	import ab4_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [VALUE_WIDTH-1:0] value_x,
	input wire logic [VALUE_WIDTH-1:0] value_y,
	input wire logic [VALUE_WIDTH-1:0] previous_x,
	input wire logic [VALUE_WIDTH-1:0] previous_y,
	input wire logic                   saturated
);

	// input stalls only when the pipe is full behind a waiting result
	property p_stall_only_when_full;
		@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready);
	endproperty
	a_stall_only_when_full: assert property (p_stall_only_when_full)
		else $error("input stalled while the result side could move");

	// a clipped result sits on a range limit
	property p_sat_at_limit;
		@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |->
			(value_x == VAL_MAX || value_x == VAL_MIN ||
			 value_y == VAL_MAX || value_y == VAL_MIN);
	endproperty
	a_sat_at_limit: assert property (p_sat_at_limit)
		else $error("saturated item with no value at a range limit");

	// a stalled result item holds
	property p_result_holds;
		@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(value_x) && $stable(value_y) &&
			 $stable(previous_x) && $stable(previous_y) && $stable(saturated));
	endproperty
	a_result_holds: assert property (p_result_holds)
		else $error("result item changed while stalled");

endmodule

bind adams_bashforth4_integrator_top ab4_checker u_ab4_checker (.*);

`default_nettype wire

### tb/sv/adams_bashforth4_integrator_top_tb.sv
// self-checking testbench for the two-component adams-bashforth integrator
module adams_bashforth4_integrator_top_tb;
	import ab4_pkg::*;

	// kinds that the block leaves without effect
	localparam logic [KIND_WIDTH-1:0] KIND_SPARE_LO  = KIND_WIDTH'(5);
	localparam logic [KIND_WIDTH-1:0] KIND_SPARE_MID = KIND_WIDTH'(6);
	localparam logic [KIND_WIDTH-1:0] KIND_SPARE_HI  = KIND_WIDTH'(7);

	localparam logic [VALUE_WIDTH-1:0] ONE_LSB  = VALUE_WIDTH'(1);
	localparam logic [VALUE_WIDTH-1:0] NEG_LSB  = '1;
	localparam logic [VALUE_WIDTH-1:0] ONE_Q    = VALUE_WIDTH'(48'h10000);
	localparam logic [VALUE_WIDTH-1:0] NEG_ONE_Q = -ONE_Q;
	localparam logic [STEP_WIDTH-1:0]  STEP_MAX  = '1;
	localparam logic [STEP_WIDTH-1:0]  STEP_HALF = STEP_WIDTH'(24'h800000);
	localparam int ITEMS_PER_PHASE = 220;
	localparam int NUM_PHASES      = 6;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value_x;
		logic [VALUE_WIDTH-1:0] value_y;
		logic [VALUE_WIDTH-1:0] previous_x;
		logic [VALUE_WIDTH-1:0] previous_y;
		logic                   saturated;
	} integ_result_t;

	typedef struct {
		logic                   write_cfg;
		logic [STEP_WIDTH-1:0]  step;
		logic [KIND_WIDTH-1:0]  op;
		logic [VALUE_WIDTH-1:0] ox;
		logic [VALUE_WIDTH-1:0] oy;
		logic                   typed;
		integ_result_t          res;
	} plan_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [STEP_WIDTH-1:0]  cfg_wr_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [KIND_WIDTH-1:0]  kind = '0;
	logic [VALUE_WIDTH-1:0] operand_x = '0;
	logic [VALUE_WIDTH-1:0] operand_y = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [VALUE_WIDTH-1:0] value_x;
	logic [VALUE_WIDTH-1:0] value_y;
	logic [VALUE_WIDTH-1:0] previous_x;
	logic [VALUE_WIDTH-1:0] previous_y;
	logic                   saturated;

	// shadow state of the integrator
	logic signed [VALUE_WIDTH-1:0] x_value, y_value, x_before, y_before;
	logic [3:0][VALUE_WIDTH-1:0]   x_slopes, y_slopes;
	logic [STEP_WIDTH-1:0]         step_now;

	integ_result_t predicted_outputs[$];
	plan_row_t     directed_rows[$];
	int            idle_pct = 32;
	int            rx_hold = 0;
	int            mismatch_count = 0;

	adams_bashforth4_integrator_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.operand_x  (operand_x),
		.operand_y  (operand_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value_x    (value_x),
		.value_y    (value_y),
		.previous_x (previous_x),
		.previous_y (previous_y),
		.saturated  (saturated)
	);

	always #5 clk = ~clk;

	// one four-tap step of one component, exact product and a single rounding
	function automatic logic integrate_lane(
		inout logic signed [VALUE_WIDTH-1:0] value,
		inout logic signed [VALUE_WIDTH-1:0] before_step,
		inout logic [3:0][VALUE_WIDTH-1:0]   slopes,
		input logic [VALUE_WIDTH-1:0]        slope
	);
		logic signed [127:0] taps;
		logic [127:0]        mag;
		logic signed [127:0] total;
		logic                neg;
		before_step = value;
		slopes = {slopes[2:0], slope};
		taps = 55 * $signed(slopes[0]) - 59 * $signed(slopes[1])
			+ 37 * $signed(slopes[2]) - 9 * $signed(slopes[3]);
		neg = taps[127];
		mag = neg ? -taps : taps;
		mag = mag * step_now;
		// divide by 24 * 2^24, round half away from zero
		mag = (mag + (128'd3 << 26)) / (128'd3 << 27);
		total = value;
		total = neg ? total - $signed(mag) : total + $signed(mag);
		if (total > VAL_MAX) begin
			value = VAL_MAX;
			return 1'b1;
		end
		if (total < VAL_MIN) begin
			value = VAL_MIN;
			return 1'b1;
		end
		value = total[VALUE_WIDTH-1:0];
		return 1'b0;
	endfunction

	// apply one item to the shadow state and return the result it gives
	function automatic integ_result_t integrate_item(
		input logic [KIND_WIDTH-1:0]  k,
		input logic [VALUE_WIDTH-1:0] ox,
		input logic [VALUE_WIDTH-1:0] oy
	);
		logic clipped;
		clipped = 1'b0;
		case (k)
			KIND_STEP_VEC: begin
				clipped = integrate_lane(x_value, x_before, x_slopes, ox);
				clipped = integrate_lane(y_value, y_before, y_slopes, oy) | clipped;
			end
			KIND_STEP_X: begin
				clipped = integrate_lane(x_value, x_before, x_slopes, ox);
			end
			KIND_LOAD_VEC: begin
				x_value = ox;
				x_before = ox;
				y_value = oy;
				y_before = oy;
				x_slopes = '0;
				y_slopes = '0;
			end
			KIND_LOAD_X: begin
				x_value = ox;
				x_before = ox;
				x_slopes = '0;
				y_slopes = '0;
			end
			KIND_CLEAR: begin
				x_value = '0;
				x_before = '0;
				y_value = '0;
				y_before = '0;
				x_slopes = '0;
				y_slopes = '0;
			end
			default: begin
			end
		endcase
		return '{x_value, y_value, x_before, y_before, clipped};
	endfunction

	// operand mix: extremes, full-width noise, and signed values of random size
	function automatic logic [VALUE_WIDTH-1:0] pick_operand();
		logic [63:0] raw;
		int          span;
		raw = {$urandom, $urandom};
		span = $urandom_range(30);
		case ($urandom_range(9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2, 3, 4: return raw[VALUE_WIDTH-1:0];
			default: return VALUE_WIDTH'($signed(raw[31:0]) >>> (31 - span));
		endcase
	endfunction

	task automatic plan_item(input logic [KIND_WIDTH-1:0] k,
		input logic [VALUE_WIDTH-1:0] ox, input logic [VALUE_WIDTH-1:0] oy);
		directed_rows.push_back('{1'b0, '0, k, ox, oy, 1'b0, '0});
	endtask

	task automatic plan_known(input logic [KIND_WIDTH-1:0] k,
		input logic [VALUE_WIDTH-1:0] ox, input logic [VALUE_WIDTH-1:0] oy,
		input integ_result_t res);
		directed_rows.push_back('{1'b0, '0, k, ox, oy, 1'b1, res});
	endtask

	task automatic plan_step(input logic [STEP_WIDTH-1:0] v);
		directed_rows.push_back('{1'b1, v, '0, '0, '0, 1'b0, '0});
	endtask

	// offer one item after a random gap and log its prediction once accepted
	task automatic send_item(input logic [KIND_WIDTH-1:0] k,
		input logic [VALUE_WIDTH-1:0] ox, input logic [VALUE_WIDTH-1:0] oy,
		input logic typed, input integ_result_t known);
		int            gap;
		integ_result_t model;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		operand_x <= ox;
		operand_y <= oy;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		model = integrate_item(k, ox, oy);
		predicted_outputs.push_back(typed ? known : model);
	endtask

	// wait for the pipeline to empty, then write the step register
	task automatic write_step(input logic [STEP_WIDTH-1:0] v);
		in_valid <= 1'b0;
		while (predicted_outputs.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		step_now = v;
	endtask

	// result side: check accepted items, then pick the next ready level
	always @(posedge clk) begin : result_side
		integ_result_t seen;
		integ_result_t want;
		if (arst_n && out_valid && out_ready) begin
			seen = '{value_x, value_y, previous_x, previous_y, saturated};
			if (predicted_outputs.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result item: x %h y %h px %h py %h sat %b",
						seen.value_x, seen.value_y, seen.previous_x, seen.previous_y,
						seen.saturated);
			end else begin
				want = predicted_outputs.pop_front();
				if (seen.value_x !== want.value_x || seen.value_y !== want.value_y ||
					seen.previous_x !== want.previous_x ||
					seen.previous_y !== want.previous_y ||
					seen.saturated !== want.saturated) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch exp: x %h y %h px %h py %h sat %b",
							want.value_x, want.value_y, want.previous_x,
							want.previous_y, want.saturated);
						$display("         got: x %h y %h px %h py %h sat %b",
							seen.value_x, seen.value_y, seen.previous_x,
							seen.previous_y, seen.saturated);
					end
				end
			end
		end
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold--;
		end else begin
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// run limit
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	// reset, directed table, then random phases over several step sizes
	initial begin
		int                    n;
		int                    r;
		int                    phase;
		logic [STEP_WIDTH-1:0] phase_step;
		logic [KIND_WIDTH-1:0] k;
		x_value = '0;
		y_value = '0;
		x_before = '0;
		y_before = '0;
		x_slopes = '0;
		y_slopes = '0;
		step_now = '0;

		// directed items
		plan_known(KIND_SPARE_HI, VAL_MAX, VAL_MIN, '{'0, '0, '0, '0, 1'b0});
		plan_step(STEP_MAX);
		plan_known(KIND_LOAD_VEC, VAL_MAX, VAL_MIN,
			'{VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, 1'b0});
		plan_item(KIND_STEP_VEC, VAL_MAX, VAL_MIN);
		plan_item(KIND_STEP_VEC, VAL_MIN, VAL_MAX);
		plan_item(KIND_STEP_X, ONE_LSB, VAL_MAX);
		plan_item(KIND_SPARE_LO, ONE_LSB, NEG_LSB);
		plan_known(KIND_CLEAR, VAL_MAX, VAL_MIN, '{'0, '0, '0, '0, 1'b0});
		plan_known(KIND_LOAD_X, VAL_MAX, VAL_MIN, '{VAL_MAX, '0, VAL_MAX, '0, 1'b0});
		plan_known(KIND_SPARE_MID, NEG_LSB, ONE_LSB,
			'{VAL_MAX, '0, VAL_MAX, '0, 1'b0});
		plan_known(KIND_LOAD_VEC, VAL_MIN, VAL_MIN,
			'{VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, 1'b0});
		plan_item(KIND_STEP_VEC, VAL_MIN, VAL_MIN);
		plan_known(KIND_LOAD_VEC, NEG_LSB, ONE_LSB,
			'{NEG_LSB, ONE_LSB, NEG_LSB, ONE_LSB, 1'b0});
		plan_item(KIND_STEP_X, NEG_LSB, '0);
		// constant slope of one lsb at half step: increment lands on exactly one half
		plan_step(STEP_HALF);
		plan_known(KIND_LOAD_VEC, '0, '0, '{'0, '0, '0, '0, 1'b0});
		repeat (4) plan_item(KIND_STEP_VEC, ONE_LSB, NEG_LSB);
		plan_item(KIND_STEP_VEC, ONE_Q, NEG_ONE_Q);
		plan_item(KIND_LOAD_X, ONE_Q, VAL_MAX);
		plan_step('0);
		plan_item(KIND_STEP_VEC, VAL_MAX, VAL_MIN);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].write_cfg)
				write_step(directed_rows[i].step);
			else
				send_item(directed_rows[i].op, directed_rows[i].ox, directed_rows[i].oy,
					directed_rows[i].typed, directed_rows[i].res);
		end

		// random phases: mostly steps between occasional loads and clears
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: phase_step = STEP_MAX;
				1: phase_step = '0;
				2: phase_step = STEP_WIDTH'(1);
				3: phase_step = STEP_HALF;
				default: phase_step = STEP_WIDTH'($urandom);
			endcase
			write_step(phase_step);
			idle_pct = (phase == 1) ? 0 : 32;
			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				// long receiver hold-off so the pipeline fills and stalls the input
				if (phase == 2 && n == 40)
					rx_hold = 300;
				r = $urandom_range(99);
				if (r < 8)
					k = KIND_LOAD_VEC;
				else if (r < 13)
					k = KIND_LOAD_X;
				else if (r < 16)
					k = KIND_CLEAR;
				else if (r < 20)
					k = KIND_WIDTH'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
				else if (r < 35)
					k = KIND_STEP_X;
				else
					k = KIND_STEP_VEC;
				send_item(k, pick_operand(), pick_operand(), 1'b0, '0);
				if (r >= 20 || r < 16)
					n++;
			end
		end

		// drain and finish
		in_valid <= 1'b0;
		while (predicted_outputs.size() != 0)
			@(posedge clk);
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
